// File: hw/rtl/bsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery status monitor package
// Shared widths, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package bsm_pkg;

   localparam int unsigned MV_W      = 16;
   localparam int unsigned TICK_W    = 32;
   localparam int unsigned MARGIN_W  = 12;
   localparam int unsigned PERIOD_W  = 16;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 16;
   localparam int unsigned REQ_DAT_W = 2 * TICK_W + MV_W;   // 80, whole bytes
   localparam int unsigned RSP_DAT_W = 8;                    // 5 flags, zero padded

   typedef enum logic {
      CMD_DETECT = 1'b0,
      CMD_UPDATE = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WARNING_MARGIN = 2'd0,
      REG_HYSTERESIS     = 2'd1,
      REG_INPUT_TIMEOUT  = 2'd2,
      REG_FLASH_PERIOD   = 2'd3
   } reg_idx_type;

   // pack windows, inclusive; fault threshold is the low bound
   localparam logic [MV_W-1:0] WIN_1S_LO = 16'd3300;
   localparam logic [MV_W-1:0] WIN_1S_HI = 16'd4200;
   localparam logic [MV_W-1:0] WIN_2S_LO = 16'd6600;
   localparam logic [MV_W-1:0] WIN_2S_HI = 16'd8400;
   localparam logic [MV_W-1:0] WIN_3S_LO = 16'd9900;
   localparam logic [MV_W-1:0] WIN_3S_HI = 16'd12600;
   localparam logic [MV_W-1:0] WIN_4S_LO = 16'd13200;
   localparam logic [MV_W-1:0] WIN_4S_HI = 16'd16800;

   localparam logic [MARGIN_W-1:0] RST_WARNING_MARGIN = 12'd200;
   localparam logic [MARGIN_W-1:0] RST_HYSTERESIS     = 12'd100;
   localparam logic [PERIOD_W-1:0] RST_INPUT_TIMEOUT  = 16'd50;
   localparam logic [PERIOD_W-1:0] RST_FLASH_PERIOD   = 16'd500;
   localparam logic [MV_W-1:0]     RST_FAULT_THR      = 16'd3300;
   localparam logic [MV_W-1:0]     RST_WARN_THR       = 16'd3500;

   // result flags, highest bit first
   typedef struct packed {
      logic red_pin;
      logic green_pin;
      logic input_fault;
      logic battery_warning;
      logic undervolt_fault;
   } status_type;

endpackage

// File: hw/rtl/battery_status_monitor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery status monitor core
// Undervoltage fault/warning with hysteresis, heartbeat timeout and LED drive.
// ----------------------------------------------------------------------------
// One item per clock, sustained while rsp_ does not stall. An accepted item
// lands in an input register; when the registers advance, the flag, threshold
// and pin logic updates the state and loads the result register, which drives
// rsp_. Both registers advance whenever the result register is empty or
// being taken, so a stall on rsp_ holds one item in each. A detect item
// (tuser 0) only re-picks the thresholds; an update item (tuser 1) moves the
// flags and pins. Every item returns one status byte.
module battery_status_monitor_core
   import bsm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_DAT_W-1:0] req_tdata,   // voltage_mv, now_ms, heartbeat_ms
   input  logic                 req_tuser,   // command

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_DAT_W-1:0] rsp_tdata,   // undervolt_fault, battery_warning,
                                             // input_fault, green_pin, red_pin, 3'b0

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   // configuration
   logic [MARGIN_W-1:0] margin_ff;
   logic [MARGIN_W-1:0] hyst_ff;
   logic [PERIOD_W-1:0] timeout_ff;
   logic [PERIOD_W-1:0] period_ff;

   // input register
   logic                 in_valid_ff;
   logic [REQ_DAT_W-1:0] in_data_ff;
   cmd_type              in_cmd_ff;

   // monitor state
   logic [MV_W-1:0]   fault_thr_ff, fault_thr_in;
   logic [MV_W-1:0]   warn_thr_ff,  warn_thr_in;
   status_type        stat_ff, stat_in;
   logic [TICK_W-1:0] toggle_tick_ff, toggle_tick_in;

   // result register
   logic       out_valid_ff;
   status_type out_stat_ff;

   logic advance;

   logic [MV_W-1:0]   volt;
   logic [TICK_W-1:0] now_tick;
   logic [TICK_W-1:0] hb_tick;
   logic [MV_W-1:0]   thr_pick;
   logic [TICK_W-1:0] hb_age;
   logic [TICK_W-1:0] flash_age;
   logic              fault_next;
   logic              warn_next;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   assign volt     = in_data_ff[MV_W-1:0];
   assign now_tick = in_data_ff[MV_W +: TICK_W];
   assign hb_tick  = in_data_ff[MV_W+TICK_W +: TICK_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff  <= RST_WARNING_MARGIN;
         hyst_ff    <= RST_HYSTERESIS;
         timeout_ff <= RST_INPUT_TIMEOUT;
         period_ff  <= RST_FLASH_PERIOD;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_addr))
            REG_WARNING_MARGIN: margin_ff  <= csr_wdata[MARGIN_W-1:0];
            REG_HYSTERESIS:     hyst_ff    <= csr_wdata[MARGIN_W-1:0];
            REG_INPUT_TIMEOUT:  timeout_ff <= csr_wdata[PERIOD_W-1:0];
            REG_FLASH_PERIOD:   period_ff  <= csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_cmd_ff  <= cmd_type'(req_tuser);
      end
   end

   // pack window lookup
   always_comb begin
      thr_pick = WIN_1S_LO;
      if (volt >= WIN_1S_LO && volt <= WIN_1S_HI) begin
         thr_pick = WIN_1S_LO;
      end else if (volt >= WIN_2S_LO && volt <= WIN_2S_HI) begin
         thr_pick = WIN_2S_LO;
      end else if (volt >= WIN_3S_LO && volt <= WIN_3S_HI) begin
         thr_pick = WIN_3S_LO;
      end else if (volt >= WIN_4S_LO && volt <= WIN_4S_HI) begin
         thr_pick = WIN_4S_LO;
      end
   end

   assign hb_age    = now_tick - hb_tick;
   assign flash_age = now_tick - toggle_tick_ff;

   // clear point is threshold + hysteresis, kept one bit wider
   assign fault_next = stat_ff.undervolt_fault
      ? !({1'b0, volt} >= ({1'b0, fault_thr_ff} + {{(MV_W+1-MARGIN_W){1'b0}}, hyst_ff}))
      : (volt <= fault_thr_ff);
   assign warn_next = stat_ff.battery_warning
      ? !({1'b0, volt} >= ({1'b0, warn_thr_ff} + {{(MV_W+1-MARGIN_W){1'b0}}, hyst_ff}))
      : (volt <= warn_thr_ff);

   always_comb begin
      fault_thr_in   = fault_thr_ff;
      warn_thr_in    = warn_thr_ff;
      stat_in        = stat_ff;
      toggle_tick_in = toggle_tick_ff;
      case (in_cmd_ff)
         CMD_DETECT: begin
            fault_thr_in = thr_pick;
            warn_thr_in  = thr_pick + {{(MV_W-MARGIN_W){1'b0}}, margin_ff};
         end
         CMD_UPDATE: begin
            stat_in.undervolt_fault = fault_next;
            stat_in.battery_warning = warn_next;
            stat_in.input_fault     = (hb_age >= {{(TICK_W-PERIOD_W){1'b0}}, timeout_ff});
            if (fault_next) begin
               stat_in.green_pin = 1'b1;
               stat_in.red_pin   = 1'b0;
            end else if (stat_in.input_fault) begin
               stat_in.red_pin = 1'b0;
               if (flash_age >= {{(TICK_W-PERIOD_W){1'b0}}, period_ff}) begin
                  stat_in.green_pin = !stat_ff.green_pin;
                  toggle_tick_in    = now_tick;
               end
            end else if (warn_next) begin
               stat_in.green_pin = 1'b1;
               stat_in.red_pin   = 1'b1;
            end else begin
               stat_in.green_pin = 1'b0;
               stat_in.red_pin   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_thr_ff   <= RST_FAULT_THR;
         warn_thr_ff    <= RST_WARN_THR;
         stat_ff        <= '0;
         toggle_tick_ff <= '0;
      end else if (advance && in_valid_ff) begin
         fault_thr_ff   <= fault_thr_in;
         warn_thr_ff    <= warn_thr_in;
         stat_ff        <= stat_in;
         toggle_tick_ff <= toggle_tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_stat_ff <= stat_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DAT_W-$bits(status_type)){1'b0}}, out_stat_ff};

endmodule

// File: hw/rtl/bsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery status monitor checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
module bsm_checker
   import bsm_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RSP_DAT_W-1:0] rsp_tdata
);

   // no result pending and input ready right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result pending or input blocked after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // battery fault has top LED priority: green on, red off
   a_fault_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[3] && !rsp_tdata[4])
      else $error("LED pins wrong under battery fault");

   // input fault never lights red
   a_timeout_red: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[4])
      else $error("red pin on during input fault");

endmodule

bind battery_status_monitor_core bsm_checker u_bsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery status monitor core testbench
// Drives detect and update items on the req_ stream at random rates, writes
// the four control registers between phases, and checks every status byte
// on the rsp_ stream against an in-bench model of thresholds, flags and pins.
// ----------------------------------------------------------------------------
module tb_top;
   import bsm_pkg::*;

   // Status expected per transfer, plus a copy of the block's state.
   class status_scoreboard;
      logic [MARGIN_W-1:0] margin_mv;
      logic [MARGIN_W-1:0] hyst_mv;
      logic [PERIOD_W-1:0] timeout_ms;
      logic [PERIOD_W-1:0] flash_ms;
      logic [MV_W-1:0]     fault_thr;
      logic [MV_W-1:0]     warn_thr;
      logic                fault_on;
      logic                warn_on;
      logic                timeout_on;
      logic                green_on;
      logic                red_on;
      logic [TICK_W-1:0]   last_toggle;
      status_type          expected_q[$];
      int                  errors;

      function new();
         margin_mv   = RST_WARNING_MARGIN;
         hyst_mv     = RST_HYSTERESIS;
         timeout_ms  = RST_INPUT_TIMEOUT;
         flash_ms    = RST_FLASH_PERIOD;
         fault_thr   = RST_FAULT_THR;
         warn_thr    = RST_WARN_THR;
         fault_on    = 1'b0;
         warn_on     = 1'b0;
         timeout_on  = 1'b0;
         green_on    = 1'b0;
         red_on      = 1'b0;
         last_toggle = '0;
         errors      = 0;
      endfunction

      function void set_reg(reg_idx_type idx, logic [CSR_DAT_W-1:0] val);
         case (idx)
            REG_WARNING_MARGIN: margin_mv  = val[MARGIN_W-1:0];
            REG_HYSTERESIS:     hyst_mv    = val[MARGIN_W-1:0];
            REG_INPUT_TIMEOUT:  timeout_ms = val[PERIOD_W-1:0];
            REG_FLASH_PERIOD:   flash_ms   = val[PERIOD_W-1:0];
            default: ;
         endcase
      endfunction

      // set at or below threshold, clear at threshold + hysteresis (no wrap)
      function logic next_flag(logic flag, logic [MV_W-1:0] mv, logic [MV_W-1:0] thr);
         if (!flag)
            return mv <= thr;
         return !(17'(mv) >= 17'(thr) + 17'(hyst_mv));
      endfunction

      function void note_request(cmd_type cmd, logic [MV_W-1:0] mv,
                                 logic [TICK_W-1:0] now, logic [TICK_W-1:0] hb);
         status_type      s;
         logic [MV_W-1:0] thr;
         if (cmd == CMD_DETECT) begin
            thr = WIN_1S_LO;
            if (mv >= WIN_2S_LO && mv <= WIN_2S_HI)
               thr = WIN_2S_LO;
            else if (mv >= WIN_3S_LO && mv <= WIN_3S_HI)
               thr = WIN_3S_LO;
            else if (mv >= WIN_4S_LO && mv <= WIN_4S_HI)
               thr = WIN_4S_LO;
            fault_thr = thr;
            warn_thr  = thr + MV_W'(margin_mv);
         end else begin
            fault_on   = next_flag(fault_on, mv, fault_thr);
            warn_on    = next_flag(warn_on, mv, warn_thr);
            timeout_on = (now - hb) >= TICK_W'(timeout_ms);
            if (fault_on) begin
               green_on = 1'b1;
               red_on   = 1'b0;
            end else if (timeout_on) begin
               red_on = 1'b0;
               if ((now - last_toggle) >= TICK_W'(flash_ms)) begin
                  green_on    = !green_on;
                  last_toggle = now;
               end
            end else if (warn_on) begin
               green_on = 1'b1;
               red_on   = 1'b1;
            end else begin
               green_on = 1'b0;
               red_on   = 1'b1;
            end
         end
         s.undervolt_fault = fault_on;
         s.battery_warning = warn_on;
         s.input_fault     = timeout_on;
         s.green_pin       = green_on;
         s.red_pin         = red_on;
         expected_q.push_back(s);
      endfunction

      function void compare(string name, logic [2:0] want, logic [2:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_status(logic [RSP_DAT_W-1:0] word);
         status_type got;
         status_type want;
         got = status_type'(word[4:0]);
         if (expected_q.size() == 0) begin
            $display("%0t: status 0x%02h arrived with nothing pending", $time, word);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare("undervolt_fault", 3'(want.undervolt_fault), 3'(got.undervolt_fault));
         compare("battery_warning", 3'(want.battery_warning), 3'(got.battery_warning));
         compare("input_fault", 3'(want.input_fault), 3'(got.input_fault));
         compare("green_pin", 3'(want.green_pin), 3'(got.green_pin));
         compare("red_pin", 3'(want.red_pin), 3'(got.red_pin));
         compare("pad bits", 3'b000, word[7:5]);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   localparam int IDLE_LIMIT    = 2000;
   localparam int PHASE_ITEMS   = 182;
   localparam int SETTLE_CYCLES = 4;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_DAT_W-1:0] req_tdata = '0;   // voltage_mv, now_ms, heartbeat_ms
   logic                 req_tuser = 1'b0; // command
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_DAT_W-1:0] rsp_tdata;        // undervolt_fault, battery_warning,
                                           // input_fault, green_pin, red_pin, 3'b0
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   status_scoreboard  sb;
   logic [TICK_W-1:0] tick;
   int                req_run = 0;
   bit                req_quiet = 1'b0;
   int                rsp_run = 0;
   bit                rsp_quiet = 1'b0;
   int                idle_cycles = 0;

   battery_status_monitor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // stretches of back-to-back traffic alternate with stretches of random gaps
   function automatic int draw_wait(inout int run_left, inout bit quiet);
      if (run_left == 0) begin
         run_left = $urandom_range(10, 60);
         quiet    = ($urandom_range(0, 2) == 0);
      end
      run_left--;
      return quiet ? 0 : $urandom_range(0, 12);
   endfunction

   task automatic send_item(cmd_type cmd, logic [MV_W-1:0] mv,
                            logic [TICK_W-1:0] now, logic [TICK_W-1:0] hb);
      int gap;
      gap = draw_wait(req_run, req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {hb, now, mv};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, mv, now, hb);
   endtask

   // block must be idle before a register write
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(logic [CSR_DAT_W-1:0] margin, logic [CSR_DAT_W-1:0] hyst,
                             logic [CSR_DAT_W-1:0] timeout, logic [CSR_DAT_W-1:0] flash);
      logic [CSR_DAT_W-1:0] vals[4];
      vals = '{margin, hyst, timeout, flash};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= reg_idx_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_reg(reg_idx_type'(i), vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_item();
      cmd_type           cmd;
      int                b;
      logic [TICK_W-1:0] age;
      logic [MV_W-1:0]   mv;
      cmd = ($urandom_range(0, 9) < 3) ? CMD_DETECT : CMD_UPDATE;
      case ($urandom_range(0, 9))
         0, 1: mv = MV_W'($urandom_range(0, 65535));
         2, 3: begin
            case ($urandom_range(0, 3))
               0: mv = MV_W'($urandom_range(WIN_1S_LO - 2, WIN_1S_HI + 2));
               1: mv = MV_W'($urandom_range(WIN_2S_LO - 2, WIN_2S_HI + 2));
               2: mv = MV_W'($urandom_range(WIN_3S_LO - 2, WIN_3S_HI + 2));
               default: mv = MV_W'($urandom_range(WIN_4S_LO - 2, WIN_4S_HI + 2));
            endcase
         end
         default: begin
            // hover around the set and clear points of both flags
            case ($urandom_range(0, 3))
               0: b = int'(sb.fault_thr);
               1: b = int'(sb.warn_thr);
               2: b = int'(sb.fault_thr) + int'(sb.hyst_mv);
               default: b = int'(sb.warn_thr) + int'(sb.hyst_mv);
            endcase
            if ($urandom_range(0, 1) == 0)
               b = b + $urandom_range(0, 4) - 2;
            else
               b = b + $urandom_range(0, 160) - 80;
            if (b < 0) b = 0;
            if (b > 65535) b = 65535;
            mv = MV_W'(b);
         end
      endcase
      case ($urandom_range(0, 19))
         0:     tick = $urandom;
         1, 2:  tick = tick + $urandom_range(0, 2 * int'(sb.flash_ms) + 2);
         default: tick = tick + $urandom_range(0, 40);
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: age = TICK_W'(sb.timeout_ms) + $urandom_range(0, 4) - 2;
         4, 5, 6:    age = $urandom_range(0, int'(sb.timeout_ms));
         7, 8:       age = $urandom_range(0, 2 * int'(sb.timeout_ms) + 2);
         default:    age = $urandom;
      endcase
      send_item(cmd, mv, tick, tick - age);
   endtask

   task automatic random_phase();
      for (int i = 0; i < PHASE_ITEMS; i++)
         random_item();
   endtask

   // stall pattern on the result side
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = draw_wait(rsp_run, rsp_quiet);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_status(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      sb   = new();
      tick = 32'd2000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: window picks and their edges
      send_item(CMD_DETECT, 16'd3300, 32'd0, 32'd0);
      send_item(CMD_DETECT, 16'd4200, 32'd0, 32'd0);
      send_item(CMD_DETECT, 16'd3299, 32'd0, 32'd0);
      send_item(CMD_DETECT, 16'd6600, 32'd0, 32'd0);
      send_item(CMD_DETECT, 16'd8400, 32'd0, 32'd0);
      send_item(CMD_DETECT, 16'd9900, 32'd0, 32'd0);
      send_item(CMD_DETECT, 16'd12600, 32'd0, 32'd0);
      send_item(CMD_DETECT, 16'd13200, 32'd0, 32'd0);
      send_item(CMD_DETECT, 16'd16800, 32'd0, 32'd0);
      send_item(CMD_DETECT, 16'd16801, 32'd0, 32'd0);
      send_item(CMD_DETECT, 16'd65535, 32'd0, 32'd0);
      send_item(CMD_DETECT, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // hysteresis on both flags around 3300 / 3500
      send_item(CMD_UPDATE, 16'd5000, 32'd1000, 32'd1000);
      send_item(CMD_UPDATE, 16'd3500, 32'd1010, 32'd1000);
      send_item(CMD_UPDATE, 16'd3300, 32'd1010, 32'd1000);
      send_item(CMD_UPDATE, 16'd3399, 32'd1010, 32'd1000);
      send_item(CMD_UPDATE, 16'd3400, 32'd1010, 32'd1000);
      send_item(CMD_UPDATE, 16'd3600, 32'd1010, 32'd1000);
      // heartbeat age just under, at, and past timeout; green flashing
      send_item(CMD_UPDATE, 16'd5000, 32'd1049, 32'd1000);
      send_item(CMD_UPDATE, 16'd5000, 32'd1050, 32'd1000);
      send_item(CMD_UPDATE, 16'd5000, 32'd1100, 32'd1000);
      send_item(CMD_UPDATE, 16'd5000, 32'd1550, 32'd1000);
      // wrapping tick difference
      send_item(CMD_UPDATE, 16'd5000, 32'd5, 32'hFFFF_FFF0);
      send_item(CMD_UPDATE, 16'd0, 32'hFFFF_FFFF, 32'd0);
      send_item(CMD_UPDATE, 16'd65535, 32'd0, 32'hFFFF_FFFF);
      random_phase();

      drain();
      write_regs(16'd0, 16'd0, 16'd1, 16'd1);
      random_phase();

      drain();
      write_regs(16'd4095, 16'd4095, 16'd65535, 16'd65535);
      random_phase();

      // upper bits of 12-bit registers are dropped; zero timeout and period
      drain();
      write_regs(16'hF123, 16'hFFFF, 16'd0, 16'd0);
      random_phase();

      drain();
      write_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      random_phase();

      drain();
      write_regs(16'($urandom_range(0, 400)), 16'($urandom_range(0, 300)),
                 16'($urandom_range(1, 100)), 16'($urandom_range(1, 200)));
      random_phase();

      drain();
      write_regs(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)),
                 16'($urandom_range(1, 1000)), 16'($urandom_range(1, 1000)));
      random_phase();

      drain();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
